// ===== design/mono_frame_circular_scroll_unit_defines.svh =====
// Assertion macros shared by the frame scroll unit.
`ifndef MONO_FRAME_CIRCULAR_SCROLL_UNIT_DEFINES_SVH
`define MONO_FRAME_CIRCULAR_SCROLL_UNIT_DEFINES_SVH

// Checks that an antecedent implies a consequent in the same cycle.
`define MFCS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mfcs check failed");

// Checks that an antecedent implies a consequent in the next cycle.
`define MFCS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mfcs check failed");

`endif

// ===== design/mfcs_pkg.sv =====
`default_nettype none
package mfcs_pkg;
    localparam int MaxWidthBytes = 16;
    localparam int MaxHeight     = 64;
    localparam int Depth         = MaxWidthBytes * MaxHeight;
    localparam int AddrW         = $clog2(Depth);
    localparam int WbW           = $clog2(MaxWidthBytes + 1);
    localparam int HW            = $clog2(MaxHeight + 1);
    localparam int ColW          = $clog2(MaxWidthBytes);
    localparam int RowW          = $clog2(MaxHeight);
    localparam int PixW          = $clog2(MaxWidthBytes * 8);
    localparam int AmtW          = 12;

    localparam logic [0:0] CfgWidth  = 1'b0;
    localparam logic [0:0] CfgHeight = 1'b1;

    typedef enum logic [1:0] {
        CMD_WRITE  = 2'd0,
        CMD_READ   = 2'd1,
        CMD_HSCROLL = 2'd2,
        CMD_VSCROLL = 2'd3
    } t_cmd;

    typedef struct packed {
        t_cmd              cmd;
        logic [AddrW-1:0]  addr;
        logic [7:0]        wdata;
        logic [PixW-1:0]   shift;   // reduced amount, pixels or rows
        logic              bad;     // address outside frame
        logic              sign;    // scroll amount was negative
    } t_job;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_LOAD,
        ST_TURN,
        ST_RWAIT,
        ST_STORE,
        ST_DONE
    } t_state;
endpackage
`default_nettype wire

// ===== design/mono_frame_circular_scroll_unit.sv =====
`default_nettype none
// Channel   | Signals                                        | Handshake
// command   | i_command i_byte_address i_write_byte i_scroll_amount | i_start & !o_busy
// config    | i_cfg_we i_cfg_index i_cfg_data                | i_cfg_we
// result    | o_read_byte o_status                           | o_done (one cycle)
// A write or a bad address passes the queue, the idle state and the done state to its result,
// a read also the read wait state; busy drops in the cycle after the result. A scroll adds
// the amount reduction, then a load pass, a turn and a store pass per row (horizontal) or
// over the whole frame (vertical), unless the amount reduces to zero.
// After reset busy stays high while the frame memory is cleared.
// Results cannot be held off; a two-entry queue decouples the front from the back.
module mono_frame_circular_scroll_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    output logic             o_busy,
    input  wire logic [1:0]  i_command,
    input  wire logic [9:0]  i_byte_address,
    input  wire logic [7:0]  i_write_byte,
    input  wire logic signed [11:0] i_scroll_amount,
    input  wire logic        i_cfg_we,
    input  wire logic [0:0]  i_cfg_index,
    input  wire logic [6:0]  i_cfg_data,
    output logic             o_done,
    output logic [7:0]       o_read_byte,
    output logic             o_status
);
    logic [4:0] r_wb_raw;
    logic [6:0] r_h_raw;
    logic [mfcs_pkg::WbW-1:0] wb;
    logic [mfcs_pkg::HW-1:0]  h;
    logic job_valid, pop, fbusy, bidle, take;
    mfcs_pkg::t_job job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wb_raw <= 5'd16;
            r_h_raw  <= 7'd32;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                mfcs_pkg::CfgWidth:  r_wb_raw <= i_cfg_data[4:0];
                mfcs_pkg::CfgHeight: r_h_raw  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign wb = (r_wb_raw == '0) ? mfcs_pkg::WbW'(1) :
                (r_wb_raw > 5'(mfcs_pkg::MaxWidthBytes)) ? mfcs_pkg::WbW'(mfcs_pkg::MaxWidthBytes) :
                mfcs_pkg::WbW'(r_wb_raw);
    assign h  = (r_h_raw == '0) ? mfcs_pkg::HW'(1) :
                (r_h_raw > 7'(mfcs_pkg::MaxHeight)) ? mfcs_pkg::HW'(mfcs_pkg::MaxHeight) :
                mfcs_pkg::HW'(r_h_raw);

    // One item at a time: busy until the back part has finished the previous one.
    assign o_busy = fbusy || job_valid || !bidle;
    assign take   = i_start && !o_busy;

    mfcs_front u_front (
        .i_clk, .i_rst_n, .i_take(take), .i_command, .i_byte_address, .i_write_byte,
        .i_scroll_amount, .i_wb(wb), .i_h(h), .i_pop(pop), .o_busy(fbusy),
        .o_job_valid(job_valid), .o_job(job)
    );

    mfcs_back u_back (
        .i_clk, .i_rst_n, .i_job_valid(job_valid), .i_job(job), .i_wb(wb), .i_h(h),
        .o_pop(pop), .o_idle(bidle), .o_valid(o_done), .o_read_byte, .o_status
    );

`include "mono_frame_circular_scroll_unit_defines.svh"
    `MFCS_ASSERT_NEXT(a_take_busy, i_clk, i_rst_n, take, o_busy)
    `MFCS_ASSERT_IMP(a_done_idle, i_clk, i_rst_n, o_done, !job_valid)
    `MFCS_ASSERT_IMP(a_bad_zero, i_clk, i_rst_n, o_done && o_status, o_read_byte == 8'd0)
endmodule
`default_nettype wire

// ===== design/mfcs_front.sv =====
`default_nettype none
// Accepts commands, checks addresses and reduces scroll amounts one step a cycle,
// then pushes a classified job into a two-entry queue.
module mfcs_front (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_take,
    input  wire logic [1:0]                  i_command,
    input  wire logic [mfcs_pkg::AddrW-1:0]  i_byte_address,
    input  wire logic [7:0]                  i_write_byte,
    input  wire logic signed [mfcs_pkg::AmtW-1:0] i_scroll_amount,
    input  wire logic [mfcs_pkg::WbW-1:0]    i_wb,
    input  wire logic [mfcs_pkg::HW-1:0]     i_h,
    input  wire logic                        i_pop,
    output logic                             o_busy,
    output logic                             o_job_valid,
    output mfcs_pkg::t_job                   o_job
);
    localparam int ModW = mfcs_pkg::AmtW + 1;

    logic                     r_red;
    logic [ModW-1:0]          r_rem;
    logic [ModW-1:0]          r_div;
    logic [3:0]               r_step;
    mfcs_pkg::t_job           r_pend;
    mfcs_pkg::t_job           r_q [2];
    logic [1:0]               r_cnt;
    logic                     r_rd;
    logic                     r_wr;
    logic [ModW-1:0]          n_rem;
    logic [ModW-1:0]          sh_div;
    logic [ModW-1:0]          size;
    logic [ModW-1:0]          amt_pos;
    logic [10:0]              lim;
    logic                     push;
    mfcs_pkg::t_job           job_in;

    assign lim = 11'(i_wb) * 11'(i_h);
    assign size = (i_command == mfcs_pkg::CMD_HSCROLL) ?
                  ModW'({i_wb, 3'b000}) : ModW'(i_h);
    // Reduce the magnitude, then fold a negative amount back into range at the end.
    assign amt_pos = i_scroll_amount[mfcs_pkg::AmtW-1] ?
                     ModW'(-$signed({i_scroll_amount[mfcs_pkg::AmtW-1], i_scroll_amount})) :
                     ModW'(i_scroll_amount);

    // Restoring reduction: subtract size shifted by r_step, one compare a cycle.
    assign sh_div = r_div << r_step;
    assign n_rem = ((r_rem >> r_step) >= r_div) ? r_rem - sh_div : r_rem;

    assign push = r_red && (r_step == 4'd0);
    always_comb begin
        job_in = r_pend;
        if (r_pend.sign && n_rem != '0) begin
            job_in.shift = mfcs_pkg::PixW'(r_div - n_rem);
        end else begin
            job_in.shift = mfcs_pkg::PixW'(n_rem);
        end
    end

    assign o_busy = r_red || (r_cnt == 2'd2) || (r_cnt == 2'd1 && !i_pop);
    assign o_job_valid = (r_cnt != 2'd0);
    assign o_job = r_q[r_rd];

    logic direct;
    mfcs_pkg::t_job job_now;
    always_comb begin
        direct = (i_command == mfcs_pkg::CMD_WRITE) || (i_command == mfcs_pkg::CMD_READ);
        job_now.cmd   = mfcs_pkg::t_cmd'(i_command);
        job_now.addr  = i_byte_address;
        job_now.wdata = i_write_byte;
        job_now.shift = '0;
        job_now.bad   = direct && (11'(i_byte_address) >= lim);
        job_now.sign  = i_scroll_amount[mfcs_pkg::AmtW-1];
    end

    logic do_push;
    mfcs_pkg::t_job push_job;
    assign do_push = (i_take && direct) || push;
    assign push_job = push ? job_in : job_now;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_red <= 1'b0;
            r_cnt <= '0;
            r_rd  <= 1'b0;
            r_wr  <= 1'b0;
        end else begin
            if (i_take && !direct) begin
                r_red  <= 1'b1;
                r_pend <= job_now;
                r_rem  <= amt_pos;
                r_div  <= size;
                r_step <= 4'd11;
            end else if (r_red) begin
                r_rem <= n_rem;
                if (r_step == 4'd0) begin
                    r_red <= 1'b0;
                end else begin
                    r_step <= r_step - 4'd1;
                end
            end
            if (do_push) begin
                r_q[r_wr] <= push_job;
                r_wr      <= ~r_wr;
            end
            if (i_pop) begin
                r_rd <= ~r_rd;
            end
            r_cnt <= r_cnt + 2'(do_push) - 2'(i_pop);
        end
    end
endmodule
`default_nettype wire

// ===== design/mfcs_back.sv =====
`default_nettype none
// Executes jobs against the frame memory. Scrolls run as a read pass of one row into
// a line buffer, then a write pass of the rotated row; vertical scrolls use a copy.
module mfcs_back (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_job_valid,
    input  wire mfcs_pkg::t_job             i_job,
    input  wire logic [mfcs_pkg::WbW-1:0]   i_wb,
    input  wire logic [mfcs_pkg::HW-1:0]    i_h,
    output logic                            o_pop,
    output logic                            o_idle,
    output logic                            o_valid,
    output logic [7:0]                      o_read_byte,
    output logic                            o_status
);
    localparam int Depth = mfcs_pkg::Depth;
    localparam int AddrW = mfcs_pkg::AddrW;
    localparam int LineBytes = mfcs_pkg::MaxWidthBytes;

    logic [7:0]        mem     [Depth];
    logic [7:0]        scr     [Depth];
    logic [7:0]        r_line  [LineBytes];
    logic [7:0]        r_rdata;
    logic [7:0]        r_sdata;

    mfcs_pkg::t_state  r_state, n_state;
    mfcs_pkg::t_job    r_job;
    logic [AddrW-1:0]  r_clr;
    logic [mfcs_pkg::RowW-1:0] r_row;
    logic [mfcs_pkg::ColW-1:0] r_col;
    logic              r_rdv;
    logic [mfcs_pkg::ColW-1:0] r_rdcol;
    logic [AddrW-1:0]  r_rdcol_a;
    logic [7:0]        r_out;
    logic              r_ovalid;
    logic              r_ost;

    logic              last_col, last_row;
    logic [AddrW-1:0]  row_base;
    logic [AddrW-1:0]  a_cur;
    logic [mfcs_pkg::RowW:0]   src_sum;
    logic [mfcs_pkg::RowW-1:0] src_row;
    logic [AddrW-1:0]  src_addr;
    logic [mfcs_pkg::PixW:0]   pix0;
    logic [mfcs_pkg::PixW-1:0] pwrap;
    logic [7:0]        rot_byte;
    logic              mem_we;
    logic [AddrW-1:0]  mem_wa;
    logic [7:0]        mem_wd;
    logic              scr_we;
    logic              hscroll;

    assign hscroll  = (r_job.cmd == mfcs_pkg::CMD_HSCROLL);
    assign last_col = (5'(r_col) == 5'(i_wb) - 5'd1);
    assign last_row = (7'(r_row) == 7'(i_h) - 7'd1);
    assign row_base = AddrW'(r_row) * AddrW'(i_wb);
    assign a_cur    = row_base + AddrW'(r_col);
    assign src_sum  = (mfcs_pkg::RowW+1)'(r_row) + (mfcs_pkg::RowW+1)'(r_job.shift);
    assign src_row  = (src_sum >= (mfcs_pkg::RowW+1)'(i_h)) ?
                      mfcs_pkg::RowW'(src_sum - (mfcs_pkg::RowW+1)'(i_h)) :
                      mfcs_pkg::RowW'(src_sum);
    assign src_addr = AddrW'(src_row) * AddrW'(i_wb) + AddrW'(r_col);

    always_comb begin
        rot_byte = '0;
        for (int b = 0; b < 8; b++) begin
            pix0 = (mfcs_pkg::PixW+1)'({r_col, 3'(b)}) + (mfcs_pkg::PixW+1)'(r_job.shift);
            if (pix0 >= (mfcs_pkg::PixW+1)'({i_wb, 3'b000})) begin
                pix0 = pix0 - (mfcs_pkg::PixW+1)'({i_wb, 3'b000});
            end
            pwrap = mfcs_pkg::PixW'(pix0);
            rot_byte[7-b] = r_line[pwrap[mfcs_pkg::PixW-1:3]][3'd7 - pwrap[2:0]];
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            mfcs_pkg::ST_CLEAR: if (r_clr == AddrW'(Depth - 1)) n_state = mfcs_pkg::ST_IDLE;
            mfcs_pkg::ST_IDLE: begin
                if (i_job_valid) begin
                    if (i_job.cmd == mfcs_pkg::CMD_READ && !i_job.bad) begin
                        n_state = mfcs_pkg::ST_RWAIT;
                    end else if ((i_job.cmd == mfcs_pkg::CMD_HSCROLL ||
                                  i_job.cmd == mfcs_pkg::CMD_VSCROLL) && i_job.shift != '0) begin
                        n_state = mfcs_pkg::ST_LOAD;
                    end else begin
                        n_state = mfcs_pkg::ST_DONE;
                    end
                end
            end
            mfcs_pkg::ST_RWAIT: n_state = mfcs_pkg::ST_DONE;
            mfcs_pkg::ST_LOAD: if (last_col && (hscroll || last_row)) n_state = mfcs_pkg::ST_TURN;
            // The last byte read in the load pass lands in the buffer during this cycle.
            mfcs_pkg::ST_TURN: n_state = mfcs_pkg::ST_STORE;
            mfcs_pkg::ST_STORE: begin
                if (last_col && (hscroll || last_row)) begin
                    if (hscroll && !last_row) n_state = mfcs_pkg::ST_LOAD;
                    else n_state = mfcs_pkg::ST_DONE;
                end
            end
            mfcs_pkg::ST_DONE: n_state = mfcs_pkg::ST_IDLE;
            default: n_state = mfcs_pkg::ST_IDLE;
        endcase
    end

    assign scr_we = r_rdv && !hscroll;

    always_comb begin
        o_pop  = (r_state == mfcs_pkg::ST_IDLE) && i_job_valid;
        mem_we = 1'b0;
        mem_wa = r_clr;
        mem_wd = '0;
        unique case (r_state)
            mfcs_pkg::ST_CLEAR: mem_we = 1'b1;
            mfcs_pkg::ST_IDLE: begin
                mem_we = i_job_valid && i_job.cmd == mfcs_pkg::CMD_WRITE && !i_job.bad;
                mem_wa = i_job.addr;
                mem_wd = i_job.wdata;
            end
            mfcs_pkg::ST_STORE: begin
                mem_we = 1'b1;
                mem_wa = a_cur;
                mem_wd = hscroll ? rot_byte : r_sdata;
            end
            default: mem_we = 1'b0;
        endcase
    end

    // The scratch copy is read in the cycle before the store pass uses it.
    logic [AddrW-1:0] scr_ra;
    always_comb begin
        scr_ra = src_addr;
        if (r_state == mfcs_pkg::ST_TURN) begin
            scr_ra = src_addr;
        end else if (!last_col) begin
            scr_ra = src_addr + AddrW'(1);
        end else if (!last_row) begin
            scr_ra = AddrW'((src_row == mfcs_pkg::RowW'(7'(i_h) - 7'd1)) ? '0 :
                     src_row + 1'b1) * AddrW'(i_wb);
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) mem[mem_wa] <= mem_wd;
        r_rdata <= mem[(r_state == mfcs_pkg::ST_IDLE) ? i_job.addr : a_cur];
        if (scr_we) scr[r_rdcol_a] <= r_rdata;
        // The first read of the store pass can hit the last byte still being copied.
        if (scr_we && r_rdcol_a == scr_ra) r_sdata <= r_rdata;
        else r_sdata <= scr[scr_ra];
    end

    always_ff @(posedge i_clk) begin
        r_rdcol_a <= a_cur;
        r_rdcol   <= r_col;
        r_rdv     <= (r_state == mfcs_pkg::ST_LOAD);
        if (r_rdv && hscroll) r_line[r_rdcol] <= r_rdata;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= mfcs_pkg::ST_CLEAR;
            r_clr    <= '0;
            r_row    <= '0;
            r_col    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= (r_state == mfcs_pkg::ST_DONE);
            if (r_state == mfcs_pkg::ST_CLEAR) r_clr <= r_clr + AddrW'(1);
            if (o_pop) begin
                r_job <= i_job;
                r_row <= '0;
                r_col <= '0;
                r_ost <= i_job.bad;
                r_out <= '0;
            end
            if (r_state == mfcs_pkg::ST_RWAIT) r_out <= r_rdata;
            if (r_state == mfcs_pkg::ST_LOAD || r_state == mfcs_pkg::ST_STORE) begin
                if (last_col) begin
                    r_col <= '0;
                    if (!hscroll && r_state == mfcs_pkg::ST_LOAD && last_row) r_row <= '0;
                    else if (!hscroll && r_state == mfcs_pkg::ST_STORE) r_row <= r_row + 1'b1;
                    else if (!hscroll) r_row <= r_row + 1'b1;
                    else if (r_state == mfcs_pkg::ST_STORE) r_row <= r_row + 1'b1;
                end else begin
                    r_col <= r_col + 1'b1;
                end
            end
        end
    end

    assign o_idle      = (r_state == mfcs_pkg::ST_IDLE) && !r_ovalid;
    assign o_valid     = r_ovalid;
    assign o_read_byte = r_out;
    assign o_status    = r_ost;
endmodule
`default_nettype wire
